### src/oks_pkg.sv
// ----------------------------------------------------------------------------
// oks_pkg
// Shared types and constants for the ordered key set core and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package oks_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef enum logic [2:0] {
		OP_INSERT = 3'd0,
		OP_DELETE = 3'd1,
		OP_EXISTS = 3'd2,
		OP_NEXT   = 3'd3,
		OP_PREV   = 3'd4,
		OP_KTH    = 3'd5
	} op_t;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] key;
	} req_t;

	typedef struct packed {
		logic               found;
		logic signed [31:0] value;
		logic               full_rejected;
	} rsp_t;

	// what one cell shows its neighbors
	typedef struct packed {
		logic signed [31:0] key;
		logic               valid;
		logic               lt;
		logic               gt;
	} nbr_t;

	// broadcast control from the sequencer to every cell
	typedef struct packed {
		logic               capture;
		logic               ins;
		logic               del;
		logic [2:0]         op;
		logic signed [31:0] key;
	} cell_ctl_t;

endpackage

`default_nettype wire

### src/oks_cell.sv
// ----------------------------------------------------------------------------
// oks_cell
// One slot of the sorted chain: holds a key, compares it with the request,
// shifts with its neighbors on insert and delete, flags itself as an answer.
// ----------------------------------------------------------------------------
`default_nettype none

module oks_cell (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [oks_pkg::IDX_W-1:0] idx,
	input  wire logic signed [31:0]        cmp_key,
	input  wire oks_pkg::cell_ctl_t        ctl,
	input  wire oks_pkg::nbr_t             left,
	input  wire oks_pkg::nbr_t             right,
	output oks_pkg::nbr_t                  self,
	output logic                           eq,
	output logic                           sel
);
	import oks_pkg::*;

	logic signed [31:0] key_q;
	logic               valid_q;
	logic               lt_q, eq_q, rk_q;
	logic               lt_c, eq_c, rk_c, gt;
	logic [31:0]        rank;

	assign rank = 32'(idx) + 32'd1;

	always_comb begin
		lt_c = valid_q && (key_q < cmp_key);
		eq_c = valid_q && (key_q == cmp_key);
		rk_c = (rank == $unsigned(cmp_key));
	end

	// compare flags, taken when a transaction is accepted
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			lt_q <= lt_c;
			eq_q <= eq_c;
			rk_q <= rk_c;
		end
	end

	assign gt = valid_q && !lt_q && !eq_q;

	always_comb begin
		case (ctl.op)
			OP_NEXT: sel = gt && !left.gt;
			OP_PREV: sel = lt_q && !right.lt;
			OP_KTH:  sel = rk_q && valid_q;
			default: sel = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.ins && !lt_q) begin
			valid_q <= left.lt ? 1'b1 : left.valid;
		end else if (ctl.del && !lt_q) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !lt_q) begin
			key_q <= left.lt ? ctl.key : left.key;
		end else if (ctl.del && !lt_q) begin
			key_q <= right.key;
		end
	end

	assign self = '{key: key_q, valid: valid_q, lt: lt_q, gt: gt};
	assign eq   = eq_q;

endmodule

`default_nettype wire

### src/ordered_key_set_core.sv
// ----------------------------------------------------------------------------
// ordered_key_set_core
// Bounded sorted set of distinct signed keys with insert, delete, exists,
// next, prev and kth lookups.
// ----------------------------------------------------------------------------
// Keys live in a row of CAPACITY cells, ascending from cell 0, valid cells
// packed at the low end. At accept each cell compares its key with the
// request key (less, equal, rank match) and stores the flags. When the
// held request moves on (no response stalled), the cells shift right
// (insert) or left (delete) from the first cell not below the key, and
// the answer is gathered from the one cell that flags itself into the
// response register. req_ready is low while a request is held, so a new
// request is taken only after the held one has moved on. The response
// register lets the next request be taken while a response still waits;
// a stalled response holds the held request back until rsp_ready frees
// the register. Reset empties the set at once through the per-cell valid
// bits; no clearing pass is needed. Insert of a present key returns found
// 0; insert into a full set returns full_rejected 1. Unknown operation codes change nothing and return zeros.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_key_set_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire oks_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_ready,
	output oks_pkg::rsp_t      rsp
);
	import oks_pkg::*;

	// request copy held between accept and the shift/answer step
	logic               v_s1;
	logic [2:0]         op_s1;
	logic signed [31:0] key_s1;

	logic      rsp_valid_q;
	rsp_t      rsp_q;

	cell_ctl_t ctl;
	nbr_t      nbr   [CAPACITY];
	logic      eq_v  [CAPACITY];
	logic      sel_v [CAPACITY];

	logic               accept, stall, step;
	logic               present, full, any_sel;
	logic signed [31:0] sel_key;
	rsp_t               rsp_c;

	assign accept    = req_valid && req_ready;
	assign stall     = rsp_valid_q && !rsp_ready;
	assign step      = v_s1 && !stall;
	assign req_ready = !v_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (step) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= req.op;
			key_s1 <= req.key;
		end
	end

	// gather flags across the row
	always_comb begin
		present = 1'b0;
		any_sel = 1'b0;
		sel_key = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			present = present | eq_v[i];
			any_sel = any_sel | sel_v[i];
			sel_key = sel_key | (nbr[i].key & {32{sel_v[i]}});
		end
	end

	assign full = nbr[CAPACITY-1].valid;

	always_comb begin
		ctl.capture = accept;
		ctl.op      = op_s1;
		ctl.key     = key_s1;
		ctl.ins     = step && (op_s1 == OP_INSERT) && !present && !full;
		ctl.del     = step && (op_s1 == OP_DELETE) && present;
	end

	always_comb begin
		rsp_c = '0;
		case (op_s1)
			OP_INSERT: begin
				rsp_c.found         = !present && !full;
				rsp_c.full_rejected = !present && full;
			end
			OP_DELETE, OP_EXISTS: begin
				rsp_c.found = present;
			end
			OP_NEXT, OP_PREV, OP_KTH: begin
				rsp_c.found = any_sel;
				rsp_c.value = sel_key;
			end
			default: rsp_c = '0;
		endcase
	end

	// cell row; the ends see a virtual neighbor: left "below key", right empty
	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		nbr_t left_n, right_n;

		if (g == 0) begin : g_first
			assign left_n = '{key: '0, valid: 1'b0, lt: 1'b1, gt: 1'b0};
		end else begin : g_mid_l
			assign left_n = nbr[g-1];
		end

		if (g == CAPACITY - 1) begin : g_last
			assign right_n = '{key: '0, valid: 1'b0, lt: 1'b0, gt: 1'b0};
		end else begin : g_mid_r
			assign right_n = nbr[g+1];
		end

		oks_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.idx     (IDX_W'(g)),
			.cmp_key (req.key),
			.ctl     (ctl),
			.left    (left_n),
			.right   (right_n),
			.self    (nbr[g]),
			.eq      (eq_v[g]),
			.sel     (sel_v[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (step) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			rsp_q <= rsp_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

### src/oks_checker.sv
// ----------------------------------------------------------------------------
// oks_checker
// Port-level checks for the ordered key set core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module oks_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire oks_pkg::req_t req,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire oks_pkg::rsp_t rsp
);
	import oks_pkg::*;

	// a waiting request holds still
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_ready |=> req_valid && $stable(req))
		else $error("request changed while waiting");

	// a waiting response holds still
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// no accept right after an accept
	a_one_per_two: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted on back-to-back cycles");

	a_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp.found && rsp.full_rejected))
		else $error("found and full_rejected both set");

	a_value_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.value != 32'sd0) |-> rsp.found)
		else $error("nonzero value without found");

endmodule

bind ordered_key_set_core oks_checker u_oks_checker (.*);

`default_nettype wire
